[rtl/fpb_pkg.sv]
package fpb_pkg;

   localparam int ID_BITS        = 16;
   localparam int COUNT_BITS     = 3;
   localparam int KIND_BITS      = 3;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [2:0] OP_FIRST_ID     = 3'd0;
   localparam logic [2:0] OP_SECOND_ID    = 3'd1;
   localparam logic [2:0] OP_FIRST_ENTRY  = 3'd2;
   localparam logic [2:0] OP_SECOND_ENTRY = 3'd3;
   localparam logic [2:0] OP_COMPUTE      = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_COUNT = 1'b1;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_FIRST_ID,
      KIND_SECOND_ID,
      KIND_FIRST_ENTRY,
      KIND_SECOND_ENTRY,
      KIND_COMPUTE
   } kind_type;

endpackage

[rtl/fpb_req_if.sv]
interface fpb_req_if #(
   parameter int MAX_VARS  = 6,
   parameter int PROB_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [2:0]            operation;
   logic [MAX_VARS-1:0]   slot;
   logic [15:0]           variable_id;
   logic [PROB_BITS-1:0]  probability;

   modport source (output valid, output operation, output slot, output variable_id,
                   output probability, input ready);
   modport sink (input valid, input operation, input slot, input variable_id,
                 input probability, output ready);
endinterface

[rtl/fpb_rsp_if.sv]
interface fpb_rsp_if #(
   parameter int MAX_VARS  = 6,
   parameter int PROB_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [MAX_VARS-1:0]   result_index;
   logic [PROB_BITS-1:0]  result_probability;
   logic                  larger_is_second;
   logic                  status;
   logic                  last;

   modport source (output valid, output result_index, output result_probability,
                   output larger_is_second, output status, output last, input ready);
   modport sink (input valid, input result_index, input result_probability,
                 input larger_is_second, input status, input last, output ready);
endinterface

[rtl/fpb_queue.sv]
module fpb_queue #(
   parameter int WIDTH = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import fpb_pkg::*;

   localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] data_ff [QUEUE_DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNTW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = data_ff[head_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[tail_ff] <= push_data;
      end
   end

endmodule

[rtl/fpb_front.sv]
module fpb_front #(
   parameter int MAX_VARS  = 6,
   parameter int PROB_BITS = 16
) (
   fpb_req_if.sink req_chan,
   input  logic    queue_full,
   output logic    push,
   output logic [fpb_pkg::KIND_BITS+MAX_VARS+fpb_pkg::ID_BITS+PROB_BITS-1:0] push_data
);
   import fpb_pkg::*;

   kind_type kind;
   logic     keep;

   assign req_chan.ready = !queue_full;

   always_comb begin
      kind = KIND_COMPUTE;
      keep = 1'b1;
      case (req_chan.operation)
         OP_FIRST_ID: begin
            kind = KIND_FIRST_ID;
            keep = (32'(req_chan.slot) < MAX_VARS);
         end
         OP_SECOND_ID: begin
            kind = KIND_SECOND_ID;
            keep = (32'(req_chan.slot) < MAX_VARS);
         end
         OP_FIRST_ENTRY: begin
            kind = KIND_FIRST_ENTRY;
         end
         OP_SECOND_ENTRY: begin
            kind = KIND_SECOND_ENTRY;
         end
         OP_COMPUTE: begin
            kind = KIND_COMPUTE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push      = req_chan.valid && !queue_full && keep;
   assign push_data = {kind, req_chan.slot, req_chan.variable_id, req_chan.probability};

endmodule

[rtl/fpb_back.sv]
module fpb_back #(
   parameter int MAX_VARS  = 6,
   parameter int PROB_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  logic [fpb_pkg::KIND_BITS+MAX_VARS+fpb_pkg::ID_BITS+PROB_BITS-1:0] head_data,
   output logic pop,
   input  logic csr_we,
   input  logic [fpb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fpb_pkg::COUNT_BITS-1:0] csr_wdata,
   fpb_rsp_if.source rsp_chan
);
   import fpb_pkg::*;

   localparam int IW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int CW    = $clog2(MAX_VARS + 1);
   localparam int QW    = KIND_BITS + MAX_VARS + ID_BITS + PROB_BITS;
   localparam int DEPTH = 1 << MAX_VARS;

   typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_ERROR, ST_RUN} state_type;

   typedef struct packed {
      logic [MAX_VARS-1:0] index;
      logic                lsec;
      logic                err;
      logic                last;
   } tag_type;

   function automatic logic [CW-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
      if (32'(c) > MAX_VARS) begin
         return CW'(MAX_VARS);
      end
      return CW'(c);
   endfunction

   kind_type               q_kind;
   logic [MAX_VARS-1:0]    q_slot;
   logic [ID_BITS-1:0]     q_id;
   logic [PROB_BITS-1:0]   q_prob;

   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  first_count_ff, first_count_in;
   logic [COUNT_BITS-1:0]  second_count_ff, second_count_in;
   logic                   lsec_ff, lsec_in;
   logic [CW-1:0]          cs_ff, cs_in;
   logic [CW-1:0]          cl_ff, cl_in;
   logic [CW-1:0]          j_ff, j_in;
   logic [MAX_VARS-1:0]    i_ff, i_in;
   logic [IW-1:0]          pos_ff [MAX_VARS];
   logic [IW-1:0]          pos_in [MAX_VARS];
   logic [IW-1:0]          seq_ff [MAX_VARS];
   logic [IW-1:0]          seq_in [MAX_VARS];
   logic [ID_BITS-1:0]     first_ids_ff [MAX_VARS];
   logic [ID_BITS-1:0]     first_ids_in [MAX_VARS];
   logic [ID_BITS-1:0]     second_ids_ff [MAX_VARS];
   logic [ID_BITS-1:0]     second_ids_in [MAX_VARS];

   logic [PROB_BITS-1:0]   first_mem [DEPTH];
   logic [PROB_BITS-1:0]   second_mem [DEPTH];
   logic [PROB_BITS-1:0]   first_rd_ff, second_rd_ff;

   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff;
   tag_type                s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic [2*PROB_BITS-1:0] prod_ff;
   logic [PROB_BITS-1:0]   s3_prob_ff;
   logic [PROB_BITS:0]     shifted;
   logic [PROB_BITS-1:0]   sat_prob;

   logic                   en;
   logic                   issue;
   tag_type                issue_tag;
   logic                   first_we, second_we;
   logic [MAX_VARS-1:0]    rd_first_addr, rd_second_addr;
   logic [MAX_VARS-1:0]    sidx;
   logic [MAX_VARS-1:0]    last_mask;
   logic                   run_last;
   logic [ID_BITS-1:0]     sid;
   logic                   found;
   logic [IW-1:0]          pos_hit, seq_hit;
   logic [CW-1:0]          c1, c2;

   assign q_kind = kind_type'(head_data[QW-1 -: KIND_BITS]);
   assign q_slot = head_data[ID_BITS+PROB_BITS +: MAX_VARS];
   assign q_id   = head_data[PROB_BITS +: ID_BITS];
   assign q_prob = head_data[PROB_BITS-1:0];

   assign en = !s3_valid_ff || rsp_chan.ready;
   assign c1 = clamp_count(first_count_ff);
   assign c2 = clamp_count(second_count_ff);

   always_comb begin
      sid     = lsec_ff ? first_ids_ff[j_ff[IW-1:0]] : second_ids_ff[j_ff[IW-1:0]];
      found   = 1'b0;
      pos_hit = '0;
      seq_hit = '0;
      for (int k = MAX_VARS - 1; k >= 0; k--) begin
         if (k < int'(cl_ff) &&
             (lsec_ff ? second_ids_ff[k] : first_ids_ff[k]) == sid) begin
            found   = 1'b1;
            pos_hit = IW'(k);
         end
         if (k < int'(cs_ff) &&
             (lsec_ff ? first_ids_ff[k] : second_ids_ff[k]) == sid) begin
            seq_hit = IW'(k);
         end
      end
   end

   always_comb begin
      sidx = '0;
      for (int m = 0; m < MAX_VARS; m++) begin
         if (m < int'(cs_ff) && i_ff[pos_ff[m]]) begin
            sidx[seq_ff[m]] = 1'b1;
         end
         last_mask[m] = (m < int'(cl_ff));
      end
   end

   assign run_last       = (i_ff == last_mask);
   assign rd_first_addr  = lsec_ff ? sidx : i_ff;
   assign rd_second_addr = lsec_ff ? i_ff : sidx;

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      lsec_in         = lsec_ff;
      cs_in           = cs_ff;
      cl_in           = cl_ff;
      j_in            = j_ff;
      i_in            = i_ff;
      pos_in          = pos_ff;
      seq_in          = seq_ff;
      first_ids_in    = first_ids_ff;
      second_ids_in   = second_ids_ff;
      pop             = 1'b0;
      first_we        = 1'b0;
      second_we       = 1'b0;
      issue           = 1'b0;
      issue_tag       = '{index: i_ff, lsec: lsec_ff, err: 1'b0, last: run_last};

      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_COUNT:  first_count_in  = csr_wdata;
            CSR_SECOND_COUNT: second_count_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            pop = head_valid;
            if (head_valid) begin
               case (q_kind)
                  KIND_FIRST_ID:     first_ids_in[q_slot[IW-1:0]] = q_id;
                  KIND_SECOND_ID:    second_ids_in[q_slot[IW-1:0]] = q_id;
                  KIND_FIRST_ENTRY:  first_we = 1'b1;
                  KIND_SECOND_ENTRY: second_we = 1'b1;
                  KIND_COMPUTE: begin
                     lsec_in  = (c1 < c2);
                     cs_in    = (c1 < c2) ? c1 : c2;
                     cl_in    = (c1 < c2) ? c2 : c1;
                     j_in     = '0;
                     state_in = ST_MATCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_MATCH: begin
            if (j_ff == cs_ff) begin
               i_in     = '0;
               state_in = ST_RUN;
            end else if (!found) begin
               state_in = ST_ERROR;
            end else begin
               pos_in[j_ff[IW-1:0]] = pos_hit;
               seq_in[j_ff[IW-1:0]] = seq_hit;
               j_in                 = j_ff + 1'b1;
            end
         end
         ST_ERROR: begin
            if (en) begin
               issue     = 1'b1;
               issue_tag = '{index: '0, lsec: lsec_ff, err: 1'b1, last: 1'b1};
               state_in  = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (en) begin
               issue = 1'b1;
               if (run_last) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign shifted  = prod_ff[2*PROB_BITS-1:PROB_BITS-1];
   assign sat_prob = shifted[PROB_BITS] ? '1 : shifted[PROB_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         if (en) begin
            s1_valid_ff <= issue;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
      lsec_ff       <= lsec_in;
      cs_ff         <= cs_in;
      cl_ff         <= cl_in;
      j_ff          <= j_in;
      i_ff          <= i_in;
      pos_ff        <= pos_in;
      seq_ff        <= seq_in;
      first_ids_ff  <= first_ids_in;
      second_ids_ff <= second_ids_in;
      if (en) begin
         s1_tag_ff  <= issue_tag;
         s2_tag_ff  <= s1_tag_ff;
         s3_tag_ff  <= s2_tag_ff;
         prod_ff    <= s1_tag_ff.err ? '0 :
                       (2*PROB_BITS)'(first_rd_ff) * (2*PROB_BITS)'(second_rd_ff);
         s3_prob_ff <= sat_prob;
      end
   end

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[q_slot] <= q_prob;
      end
      if (en) begin
         first_rd_ff <= first_mem[rd_first_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (second_we) begin
         second_mem[q_slot] <= q_prob;
      end
      if (en) begin
         second_rd_ff <= second_mem[rd_second_addr];
      end
   end

   assign rsp_chan.valid              = s3_valid_ff;
   assign rsp_chan.result_index       = s3_tag_ff.index;
   assign rsp_chan.result_probability = s3_prob_ff;
   assign rsp_chan.larger_is_second   = s3_tag_ff.lsec;
   assign rsp_chan.status             = s3_tag_ff.err;
   assign rsp_chan.last               = s3_tag_ff.last;

endmodule

[rtl/factor_product_binary.sv]
// Product of two probability tables over binary variables. Load transfers pass a
// two-entry queue and are executed one per cycle while no compute is running; ids
// go to registers and table entries to two memories. A compute transfer first
// locates each variable of the smaller factor in the larger factor's id list, and
// then streams one result per cycle while the response channel is ready, 2^n
// results for a larger factor of n variables, through a read, multiply and
// saturate pipeline; each table memory is read through a single port. A missing
// variable ends the search early and yields one error result.
// Configuration writes to the variable counts take effect on the next compute.
module factor_product_binary #(
   parameter int MAX_VARS  = 6,
   parameter int PROB_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   fpb_req_if.sink                             req_chan,
   fpb_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [fpb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fpb_pkg::COUNT_BITS-1:0]      csr_wdata
);
   import fpb_pkg::*;

   localparam int QW = KIND_BITS + MAX_VARS + ID_BITS + PROB_BITS;

   logic          push, queue_full, pop, head_valid;
   logic [QW-1:0] push_data, head_data;

   fpb_front #(.MAX_VARS(MAX_VARS), .PROB_BITS(PROB_BITS)) u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   fpb_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   fpb_back #(.MAX_VARS(MAX_VARS), .PROB_BITS(PROB_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_chan   (rsp_chan)
   );

endmodule
